>>> sv/sensor_filter_mode_selector_macros.svh
// ----------------------------------------------------------------------------
// Sensor filter mode selector assertion macros
// Shared concurrent check forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SENSOR_FILTER_MODE_SELECTOR_MACROS_SVH
`define SENSOR_FILTER_MODE_SELECTOR_MACROS_SVH

// same-cycle implication
`define SFMS_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sfms check failed");

// next-cycle implication
`define SFMS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sfms check failed");

`endif

>>> sv/sfms_pkg.sv
// ----------------------------------------------------------------------------
// Sensor filter mode selector package
// Shared widths, codes, transaction types and the level classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package sfms_pkg;

   localparam int SAMPLE_BITS   = 12;
   localparam int CFG_BITS      = 12;
   localparam int CMD_BITS      = 8;
   localparam int CSR_ADDR_BITS = 3;
   localparam int AVG_LOG2_DEF  = 3;
   localparam int REQ_DATA_BITS = 24;
   localparam int RSP_DATA_BITS = 32;

   localparam logic [CMD_BITS-1:0] SINGLE_CMD = 8'hFF;

   typedef enum logic [1:0] {
      WIPER_OFF      = 2'd0,
      WIPER_INTERVAL = 2'd1,
      WIPER_LOW      = 2'd2,
      WIPER_HIGH     = 2'd3
   } mode_type;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_SAMPLE_FLOOR   = 3'd0,
      CSR_SAMPLE_CEILING = 3'd1,
      CSR_JUMP_LIMIT     = 3'd2,
      CSR_LEVEL_OFF_INT  = 3'd3,
      CSR_LEVEL_INT_LOW  = 3'd4,
      CSR_LEVEL_LOW_HIGH = 3'd5
   } csr_idx_type;

   typedef struct packed {
      logic [CFG_BITS-1:0] level_low_high;
      logic [CFG_BITS-1:0] level_int_low;
      logic [CFG_BITS-1:0] level_off_int;
      logic [CFG_BITS-1:0] jump_limit;
      logic [CFG_BITS-1:0] sample_ceiling;
      logic [CFG_BITS-1:0] sample_floor;
   } cfg_type;

   // last member sits in the lowest bits
   typedef struct packed {
      logic                   send_slot;
      mode_type               host_mode;
      logic                   host_control;
      logic                   remote_stuck;
      logic                   link_fault;
      logic                   btn_single;
      logic                   btn_toggle;
      logic [SAMPLE_BITS-1:0] adc_sample;
   } req_item_type;

   typedef struct packed {
      logic                   trigger_pending;
      logic [CMD_BITS-1:0]    command_byte;
      logic                   command_valid;
      logic [SAMPLE_BITS-1:0] filtered_level;
      logic                   fault_now;
      logic                   manual_on;
      mode_type               wiper_mode;
   } rsp_item_type;

   typedef struct packed {
      logic                   fault;
      logic [SAMPLE_BITS-1:0] level;
   } filt_status_type;

   function automatic mode_type classify(input logic [SAMPLE_BITS-1:0] level,
                                         input cfg_type cfg);
      mode_type m;
      if (level < cfg.level_off_int) begin
         m = WIPER_OFF;
      end else if (level < cfg.level_int_low) begin
         m = WIPER_INTERVAL;
      end else if (level < cfg.level_low_high) begin
         m = WIPER_LOW;
      end else begin
         m = WIPER_HIGH;
      end
      return m;
   endfunction

endpackage

`default_nettype wire

>>> sv/sensor_filter_mode_selector.sv
// Accepted requests go to the input stage, then to the result register that
// drives rsp_tvalid; one transaction per cycle unless rsp_tready stalls. The
// two registers decouple the sides, so req_tready stays high as results move.
// Reset (synchronous, active high) clears control state, the filter line
// and sum, and loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
// Sensor filter mode selector top level
// Input stage, filter, mode selector, result register and config registers.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sensor_filter_mode_selector_macros.svh"

module sensor_filter_mode_selector #(
   parameter int AVG_LOG2 = sfms_pkg::AVG_LOG2_DEF
) (
   input  wire                                    clock,
   input  wire                                    reset,
   // adc_sample[11:0], btn_toggle, btn_single, link_fault, remote_stuck,
   // host_control, host_mode[1:0], send_slot, zero fill
   input  wire  [sfms_pkg::REQ_DATA_BITS-1:0]     req_tdata,
   input  wire                                    req_tvalid,
   output logic                                   req_tready,
   // wiper_mode[1:0], manual_on, fault_now, filtered_level[11:0],
   // command_valid, command_byte[7:0], trigger_pending, zero fill
   output logic [sfms_pkg::RSP_DATA_BITS-1:0]     rsp_tdata,
   output logic                                   rsp_tvalid,
   input  wire                                    rsp_tready,
   input  wire                                    csr_we,
   input  wire  [sfms_pkg::CSR_ADDR_BITS-1:0]     csr_addr,
   input  wire  [sfms_pkg::CFG_BITS-1:0]          csr_wdata
);
   import sfms_pkg::*;

   localparam int REQ_ITEM_BITS = $bits(req_item_type);
   localparam int RSP_ITEM_BITS = $bits(rsp_item_type);

   cfg_type         cfg_ff;
   logic            s1_valid_ff;
   req_item_type    s1_item_ff;
   logic            rsp_valid_ff;
   rsp_item_type    rsp_item_ff;
   rsp_item_type    result;
   filt_status_type status;
   logic            advance;

   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_BITS-RSP_ITEM_BITS){1'b0}}, rsp_item_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sample_floor   <= CFG_BITS'(100);
         cfg_ff.sample_ceiling <= CFG_BITS'(4000);
         cfg_ff.jump_limit     <= CFG_BITS'(500);
         cfg_ff.level_off_int  <= CFG_BITS'(1000);
         cfg_ff.level_int_low  <= CFG_BITS'(2000);
         cfg_ff.level_low_high <= CFG_BITS'(3000);
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_addr))
            CSR_SAMPLE_FLOOR:   cfg_ff.sample_floor   <= csr_wdata;
            CSR_SAMPLE_CEILING: cfg_ff.sample_ceiling <= csr_wdata;
            CSR_JUMP_LIMIT:     cfg_ff.jump_limit     <= csr_wdata;
            CSR_LEVEL_OFF_INT:  cfg_ff.level_off_int  <= csr_wdata;
            CSR_LEVEL_INT_LOW:  cfg_ff.level_int_low  <= csr_wdata;
            CSR_LEVEL_LOW_HIGH: cfg_ff.level_low_high <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_item_ff <= req_item_type'(req_tdata[REQ_ITEM_BITS-1:0]);
      end
      if (advance) begin
         rsp_item_ff <= result;
      end
   end

   sfms_filter #(
      .AVG_LOG2 (AVG_LOG2)
   ) u_filter (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (s1_item_ff),
      .cfg     (cfg_ff),
      .status  (status)
   );

   sfms_mode u_mode (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (s1_item_ff),
      .cfg     (cfg_ff),
      .status  (status),
      .result  (result)
   );

   `SFMS_ASSERT_SAME(a_fault_forces_off, rsp_valid_ff && rsp_item_ff.fault_now, rsp_item_ff.wiper_mode == WIPER_OFF)
   `SFMS_ASSERT_SAME(a_no_cmd_zero, rsp_valid_ff && !rsp_item_ff.command_valid, rsp_item_ff.command_byte == '0)
   `SFMS_ASSERT_SAME(a_single_manual, rsp_valid_ff && (rsp_item_ff.command_byte == SINGLE_CMD), rsp_item_ff.manual_on && !rsp_item_ff.trigger_pending)
   `SFMS_ASSERT_NEXT(a_advance_gives_rsp, advance, rsp_valid_ff)

endmodule

`default_nettype wire

>>> sv/sfms_filter.sv
// ----------------------------------------------------------------------------
// Sensor filter
// Range and jump fault check, boxcar moving average over a shift line.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sensor_filter_mode_selector_macros.svh"

module sfms_filter #(
   parameter int AVG_LOG2 = sfms_pkg::AVG_LOG2_DEF
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      advance,
   input  sfms_pkg::req_item_type   item,
   input  sfms_pkg::cfg_type        cfg,
   output sfms_pkg::filt_status_type status
);
   import sfms_pkg::*;

   localparam int RING_DEPTH = 1 << AVG_LOG2;
   localparam int SUM_W      = SAMPLE_BITS + AVG_LOG2;

   logic [SAMPLE_BITS-1:0] prev_ff;
   logic [SAMPLE_BITS-1:0] level_ff;
   logic [SAMPLE_BITS-1:0] level_in;
   logic [SUM_W-1:0]       sum_ff;
   logic [SUM_W-1:0]       sum_in;
   logic [SAMPLE_BITS-1:0] ring_ff [RING_DEPTH];
   logic [SAMPLE_BITS-1:0] sample;
   logic [SAMPLE_BITS-1:0] delta;
   logic                   healthy;
   logic                   stable;
   logic                   fault;

   assign sample  = item.adc_sample;
   assign healthy = (sample >= cfg.sample_floor) && (sample <= cfg.sample_ceiling);
   assign delta   = (sample > prev_ff) ? (sample - prev_ff) : (prev_ff - sample);
   assign stable  = delta <= cfg.jump_limit;
   assign fault   = !healthy || !stable || item.link_fault || item.remote_stuck;

   assign sum_in   = sum_ff + SUM_W'(sample) - SUM_W'(ring_ff[RING_DEPTH-1]);
   assign level_in = fault ? level_ff : sum_in[AVG_LOG2 +: SAMPLE_BITS];

   assign status.fault = fault;
   assign status.level = level_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         level_ff <= '0;
         sum_ff   <= '0;
         for (int i = 0; i < RING_DEPTH; i++) begin
            ring_ff[i] <= '0;
         end
      end else if (advance) begin
         prev_ff <= sample;
         if (!fault) begin
            level_ff   <= level_in;
            sum_ff     <= sum_in;
            ring_ff[0] <= sample;
            for (int i = 1; i < RING_DEPTH; i++) begin
               ring_ff[i] <= ring_ff[i-1];
            end
         end
      end
   end

   `SFMS_ASSERT_NEXT(a_fault_freezes_sum, advance && fault, $stable(sum_ff))
   `SFMS_ASSERT_NEXT(a_fault_freezes_level, advance && fault, $stable(level_ff))
   `SFMS_ASSERT_NEXT(a_idle_holds_sum, !advance, $stable(sum_ff) && $stable(prev_ff))

endmodule

`default_nettype wire

>>> sv/sfms_mode.sv
// ----------------------------------------------------------------------------
// Mode selector
// Manual/auto control, single trigger arming and command byte generation.
// ----------------------------------------------------------------------------
`default_nettype none

module sfms_mode (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       advance,
   input  sfms_pkg::req_item_type    item,
   input  sfms_pkg::cfg_type         cfg,
   input  sfms_pkg::filt_status_type status,
   output sfms_pkg::rsp_item_type    result
);
   import sfms_pkg::*;

   logic     manual_ff;
   logic     manual_in;
   logic     pending_ff;
   logic     pending_in;
   logic     armed;
   mode_type mode_ff;
   mode_type mode_in;
   logic     single_cmd;

   always_comb begin
      manual_in = manual_ff ^ item.btn_toggle;
      armed     = pending_ff || (item.btn_single && manual_in);
      mode_in   = mode_ff;
      if (status.fault || (item.btn_toggle && manual_in)) begin
         mode_in = WIPER_OFF;
      end
      if (!status.fault && !manual_in) begin
         mode_in = item.host_control ? item.host_mode : classify(status.level, cfg);
      end
      single_cmd = item.send_slot && manual_in && armed;
      pending_in = armed && !single_cmd;
   end

   always_comb begin
      result.wiper_mode      = mode_in;
      result.manual_on       = manual_in;
      result.fault_now       = status.fault;
      result.filtered_level  = status.level;
      result.command_valid   = item.send_slot;
      result.trigger_pending = pending_in;
      if (single_cmd) begin
         result.command_byte = SINGLE_CMD;
      end else if (item.send_slot) begin
         result.command_byte = CMD_BITS'(mode_in);
      end else begin
         result.command_byte = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         manual_ff  <= 1'b0;
         pending_ff <= 1'b0;
         mode_ff    <= WIPER_OFF;
      end else if (advance) begin
         manual_ff  <= manual_in;
         pending_ff <= pending_in;
         mode_ff    <= mode_in;
      end
   end

endmodule

`default_nettype wire
